FILE: src/nae_pkg.sv
`default_nettype none
package nae_pkg;

   localparam logic [2:0] OP_WR_FEATURE = 3'd0;
   localparam logic [2:0] OP_WR_BIAS    = 3'd1;
   localparam logic [2:0] OP_WR_OUTPUT  = 3'd2;
   localparam logic [2:0] OP_RESET_ACC  = 3'd3;
   localparam logic [2:0] OP_ADD_PIECE  = 3'd4;
   localparam logic [2:0] OP_REM_PIECE  = 3'd5;
   localparam logic [2:0] OP_EVALUATE   = 3'd6;
   localparam logic [2:0] OP_UNUSED     = 3'd7;

   localparam logic [2:0] CSR_OUTPUT_BIAS  = 3'd0;
   localparam logic [2:0] CSR_CLIP_CEILING = 3'd1;
   localparam logic [2:0] CSR_OUTPUT_QUANT = 3'd2;
   localparam logic [2:0] CSR_EVAL_SCALE   = 3'd3;
   localparam logic [2:0] CSR_EVAL_LIMIT   = 3'd4;

   localparam logic [15:0] RST_OUTPUT_BIAS  = 16'd0;
   localparam logic [14:0] RST_CLIP_CEILING = 15'd255;
   localparam logic [14:0] RST_OUTPUT_QUANT = 15'd64;
   localparam logic [15:0] RST_EVAL_SCALE   = 16'd400;
   localparam logic [14:0] RST_EVAL_LIMIT   = 15'd9999;

   localparam int          FEATURE_ROWS = 768;
   localparam logic [5:0]  MIRROR       = 6'd56;
   localparam logic [2:0]  PIECE_KINDS  = 3'd6;
   localparam int          DIV_W        = 50;
   localparam int          DVS_W        = 30;

   typedef struct packed {
      logic ld;
      logic setup;
      logic issue;
      logic pass;
      logic div_start;
      logic div_sel;
      logic mul;
      logic fin;
   } nae_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       piece_ok;
      logic       div_busy;
      logic       div_done;
   } nae_stat_type;

endpackage
`default_nettype wire

FILE: src/nae_div.sv
`default_nettype none
module nae_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [nae_pkg::DIV_W-1:0]   dividend,
   input  wire logic        [nae_pkg::DVS_W-1:0]   divisor,
   output logic                                    busy,
   output logic                                    done,
   output logic signed [nae_pkg::DIV_W-1:0]        quotient
);
   localparam int DW = nae_pkg::DIV_W;
   localparam int VW = nae_pkg::DVS_W;
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[DW-1];
         quo_in  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      end else if (busy_ff) begin
         if (!diff[VW]) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -signed'(quo_ff) : signed'(quo_ff);

endmodule
`default_nettype wire

FILE: src/nae_datapath.sv
`default_nettype none
module nae_datapath #(
   parameter int HIDDEN = 128
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire nae_pkg::nae_cmd_type      cmd,
   input  wire logic [$clog2(HIDDEN)-1:0] sweep_lane,
   output nae_pkg::nae_stat_type          stat,
   input  wire logic [2:0]                req_op,
   input  wire logic [9:0]                req_row,
   input  wire logic [6:0]                req_lane,
   input  wire logic signed [15:0]        req_weight_value,
   input  wire logic [2:0]                req_piece,
   input  wire logic [5:0]                req_square,
   input  wire logic                      req_white_piece,
   input  wire logic                      req_white_turn,
   input  wire logic                      csr_write_enable,
   input  wire logic [2:0]                csr_index,
   input  wire logic [15:0]               csr_write_data,
   output logic signed [15:0]             rsp_score
);
   localparam int LW  = $clog2(HIDDEN);
   localparam int FW  = $clog2(nae_pkg::FEATURE_ROWS * HIDDEN);
   localparam int OWW = $clog2(2 * HIDDEN);
   localparam int DW  = nae_pkg::DIV_W;
   localparam int VW  = nae_pkg::DVS_W;

   logic signed [15:0] feat_mem [nae_pkg::FEATURE_ROWS * HIDDEN];
   logic signed [15:0] bias_mem [HIDDEN];
   logic signed [15:0] ow_mem   [2 * HIDDEN];
   logic signed [15:0] accw_mem [HIDDEN];
   logic signed [15:0] accb_mem [HIDDEN];

   logic [15:0] bias_cfg_ff, scale_ff;
   logic [14:0] clip_ff, quant_ff, limit_ff;
   logic [14:0] qa, qb;

   logic [2:0]         op_ff;
   logic [9:0]         row_ff;
   logic [6:0]         lane_ff;
   logic signed [15:0] wv_ff;
   logic [2:0]         piece_ff;
   logic [5:0]         square_ff;
   logic               white_ff, wtm_ff;

   logic [LW-1:0] lane_ix;
   logic          lane_ok;
   logic [5:0]    sq_m;
   logic [9:0]    row_w, row_b;
   logic [FW-1:0] base_w_ff, base_b_ff, feat_ra;
   logic [VW-1:0] qaqb_ff;

   logic signed [15:0] feat_q_ff, bias_q_ff, ow_q_ff, accw_q_ff, accb_q_ff;
   logic               v1_ff, v2_ff, v3_ff;
   logic [LW-1:0]      l1_ff;
   logic               p1_ff;
   logic signed [15:0] a_sel, upd_val;
   logic [14:0]        c_val, c2_ff;
   logic signed [31:0] t_full, p_full;
   logic signed [15:0] t16_ff;
   logic signed [31:0] p3_ff, sum_ff;
   logic               is_upd;

   logic                 div_busy, div_done;
   logic signed [DW-1:0] div_res, div_dvd, prod_ff;
   logic [VW-1:0]        div_dvs;
   logic signed [33:0]   s_bias;
   logic signed [50:0]   prod_full;
   logic signed [DW-1:0] lim;
   logic signed [15:0]   score_ff;

   assign qa = (clip_ff == '0) ? 15'd1 : clip_ff;
   assign qb = (quant_ff == '0) ? 15'd1 : quant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_cfg_ff <= nae_pkg::RST_OUTPUT_BIAS;
         clip_ff     <= nae_pkg::RST_CLIP_CEILING;
         quant_ff    <= nae_pkg::RST_OUTPUT_QUANT;
         scale_ff    <= nae_pkg::RST_EVAL_SCALE;
         limit_ff    <= nae_pkg::RST_EVAL_LIMIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            nae_pkg::CSR_OUTPUT_BIAS:  bias_cfg_ff <= csr_write_data;
            nae_pkg::CSR_CLIP_CEILING: clip_ff     <= csr_write_data[14:0];
            nae_pkg::CSR_OUTPUT_QUANT: quant_ff    <= csr_write_data[14:0];
            nae_pkg::CSR_EVAL_SCALE:   scale_ff    <= csr_write_data;
            nae_pkg::CSR_EVAL_LIMIT:   limit_ff    <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld) begin
         op_ff     <= req_op;
         row_ff    <= req_row;
         lane_ff   <= req_lane;
         wv_ff     <= req_weight_value;
         piece_ff  <= req_piece;
         square_ff <= req_square;
         white_ff  <= req_white_piece;
         wtm_ff    <= req_white_turn;
      end
   end

   assign lane_ix = LW'(lane_ff);
   assign lane_ok = 32'(lane_ff) < 32'(HIDDEN);
   assign sq_m    = square_ff ^ nae_pkg::MIRROR;
   assign row_w   = white_ff ? {1'b0, piece_ff, square_ff}
                             : {4'(piece_ff) + 4'(nae_pkg::PIECE_KINDS), square_ff};
   assign row_b   = white_ff ? {4'(piece_ff) + 4'(nae_pkg::PIECE_KINDS), sq_m}
                             : {1'b0, piece_ff, sq_m};

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         base_w_ff <= FW'(32'(row_w) * HIDDEN);
         base_b_ff <= FW'(32'(row_b) * HIDDEN);
         qaqb_ff   <= VW'(qa) * VW'(qb);
      end
   end

   // writes from requests, and registered reads for the lane sweep
   always_ff @(posedge clock) begin
      if (cmd.setup && op_ff == nae_pkg::OP_WR_FEATURE && lane_ok
          && 32'(row_ff) < nae_pkg::FEATURE_ROWS)
         feat_mem[FW'(32'(row_ff) * HIDDEN + 32'(lane_ff))] <= wv_ff;
      feat_q_ff <= feat_mem[feat_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.setup && op_ff == nae_pkg::OP_WR_BIAS && lane_ok)
         bias_mem[lane_ix] <= wv_ff;
      bias_q_ff <= bias_mem[sweep_lane];
   end

   always_ff @(posedge clock) begin
      if (cmd.setup && op_ff == nae_pkg::OP_WR_OUTPUT && lane_ok && row_ff <= 10'd1)
         ow_mem[OWW'(32'(row_ff[0]) * HIDDEN + 32'(lane_ff))] <= wv_ff;
      ow_q_ff <= ow_mem[OWW'(32'(cmd.pass) * HIDDEN + 32'(sweep_lane))];
   end

   assign feat_ra = (cmd.pass ? base_b_ff : base_w_ff) + FW'(sweep_lane);
   assign is_upd  = (op_ff == nae_pkg::OP_ADD_PIECE) || (op_ff == nae_pkg::OP_REM_PIECE);

   always_comb begin
      a_sel = p1_ff ? accb_q_ff : accw_q_ff;
      if (op_ff == nae_pkg::OP_REM_PIECE) upd_val = a_sel - feat_q_ff;
      else upd_val = a_sel + feat_q_ff;
   end

   always_ff @(posedge clock) begin
      if (v1_ff && (op_ff == nae_pkg::OP_RESET_ACC || (is_upd && !p1_ff)))
         accw_mem[l1_ff] <= (op_ff == nae_pkg::OP_RESET_ACC) ? bias_q_ff : upd_val;
      accw_q_ff <= accw_mem[sweep_lane];
   end

   always_ff @(posedge clock) begin
      if (v1_ff && (op_ff == nae_pkg::OP_RESET_ACC || (is_upd && p1_ff)))
         accb_mem[l1_ff] <= (op_ff == nae_pkg::OP_RESET_ACC) ? bias_q_ff : upd_val;
      accb_q_ff <= accb_mem[sweep_lane];
   end

   // evaluation multiply-accumulate
   always_comb begin
      logic signed [15:0] a;
      a = (p1_ff ^ wtm_ff) ? accw_q_ff : accb_q_ff;
      if (a[15]) c_val = '0;
      else if (a[14:0] > qa) c_val = qa;
      else c_val = a[14:0];
      t_full = signed'({1'b0, c_val}) * ow_q_ff;
      p_full = signed'({1'b0, c2_ff}) * t16_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff && (op_ff == nae_pkg::OP_EVALUATE);
         v3_ff <= v2_ff;
      end
      l1_ff  <= sweep_lane;
      p1_ff  <= cmd.pass;
      c2_ff  <= c_val;
      t16_ff <= t_full[15:0];
      p3_ff  <= p_full;
      if (cmd.setup) sum_ff <= '0;
      else if (v3_ff) sum_ff <= sum_ff + p3_ff;
   end

   assign div_dvd = cmd.div_sel ? prod_ff : DW'(sum_ff);
   assign div_dvs = cmd.div_sel ? qaqb_ff : VW'(qa);

   nae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_res)
   );

   assign s_bias    = 34'(signed'(div_res[32:0])) + 34'(signed'(bias_cfg_ff));
   assign prod_full = s_bias * signed'({1'b0, scale_ff});
   assign lim       = signed'(DW'(limit_ff));

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= prod_full[DW-1:0];
      if (cmd.fin) begin
         if (div_res > lim) score_ff <= signed'({1'b0, limit_ff});
         else if (div_res < -lim) score_ff <= -signed'({1'b0, limit_ff});
         else score_ff <= div_res[15:0];
      end
   end

   assign rsp_score     = score_ff;
   assign stat.op       = op_ff;
   assign stat.piece_ok = piece_ff < nae_pkg::PIECE_KINDS;
   assign stat.div_busy = div_busy;
   assign stat.div_done = div_done;

endmodule
`default_nettype wire

FILE: src/nae_ctrl.sv
`default_nettype none
module nae_ctrl #(
   parameter int HIDDEN = 128
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire nae_pkg::nae_stat_type     stat,
   output nae_pkg::nae_cmd_type           cmd,
   output logic [$clog2(HIDDEN)-1:0]      sweep_lane
);
   localparam int LW = $clog2(HIDDEN);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_SWEEP = 4'd2;
   localparam logic [3:0] S_DRAIN = 4'd3;
   localparam logic [3:0] S_DIV1S = 4'd4;
   localparam logic [3:0] S_DIV1W = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_DIV2S = 4'd7;
   localparam logic [3:0] S_DIV2W = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] lane_ff, lane_in;
   logic          pass_ff, pass_in;
   logic [1:0]    drain_ff, drain_in;

   always_comb begin
      state_in  = state_ff;
      lane_in   = lane_ff;
      pass_in   = pass_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.pass  = pass_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.ld   = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            lane_in   = '0;
            pass_in   = 1'b0;
            drain_in  = '0;
            case (stat.op)
               nae_pkg::OP_RESET_ACC,
               nae_pkg::OP_EVALUATE:  state_in = S_SWEEP;
               nae_pkg::OP_ADD_PIECE,
               nae_pkg::OP_REM_PIECE: state_in = stat.piece_ok ? S_SWEEP : S_IDLE;
               default:               state_in = S_IDLE;
            endcase
         end
         S_SWEEP: begin
            cmd.issue = 1'b1;
            if (lane_ff == LW'(HIDDEN - 1)) begin
               lane_in = '0;
               if (pass_ff || stat.op == nae_pkg::OP_RESET_ACC) state_in = S_DRAIN;
               else pass_in = 1'b1;
            end else begin
               lane_in = lane_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd3)
               state_in = (stat.op == nae_pkg::OP_EVALUATE) ? S_DIV1S : S_IDLE;
         end
         S_DIV1S: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV1W;
         end
         S_DIV1W: begin
            if (stat.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV2S;
         end
         S_DIV2S: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = S_DIV2W;
         end
         S_DIV2W: begin
            if (stat.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lane_ff  <= '0;
         pass_ff  <= 1'b0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         pass_ff  <= pass_in;
         drain_ff <= drain_in;
      end
   end

   assign sweep_lane = lane_ff;

endmodule
`default_nettype wire

FILE: src/nnue_accumulator_evaluator.sv
// NNUE evaluator with incremental accumulators and a squared clipped-ReLU output.
// Request channel: req_valid/req_stall carry one request (op and its fields).
// A request is taken when req_valid is high and req_stall low; the block takes
// one request at a time and holds req_stall high until it has finished.
// Response channel: rsp_valid/rsp_stall carry one score, for evaluate only.
// Request timing is set by the single lane sweep and the bit-serial divider:
//   weight writes and ignored ops: no lane sweep
//   reset accumulators: one sweep over the HIDDEN lanes
//   add or remove piece: two sweeps (one lane per cycle per side)
//   evaluate: two sweeps, one multiply-accumulate per lane, then two restoring
//   divisions before rsp_valid. A stalled response holds its score and blocks
// the next request. Configuration writes on csr_* take effect at once; the
// user must make them while idle, as the block does not enforce it.
// Reset is synchronous: control state and configuration registers return to
// their defaults; weight memories and accumulators stay undefined until written.
`default_nettype none
module nnue_accumulator_evaluator #(
   parameter int HIDDEN = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic [9:0]         req_row,
   input  wire logic [6:0]         req_lane,
   input  wire logic signed [15:0] req_weight_value,
   input  wire logic [2:0]         req_piece,
   input  wire logic [5:0]         req_square,
   input  wire logic               req_white_piece,
   input  wire logic               req_white_turn,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_score,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_write_data
);
   nae_pkg::nae_cmd_type         cmd;
   nae_pkg::nae_stat_type        stat;
   logic [$clog2(HIDDEN)-1:0]    sweep_lane;

   nae_ctrl #(.HIDDEN(HIDDEN)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd),
      .sweep_lane (sweep_lane)
   );

   nae_datapath #(.HIDDEN(HIDDEN)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sweep_lane        (sweep_lane),
      .stat              (stat),
      .req_op            (req_op),
      .req_row           (req_row),
      .req_lane          (req_lane),
      .req_weight_value  (req_weight_value),
      .req_piece         (req_piece),
      .req_square        (req_square),
      .req_white_piece   (req_white_piece),
      .req_white_turn    (req_white_turn),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_score         (rsp_score)
   );

`ifndef SYNTHESIS
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid) else $error("request taken while response pending");
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy) else $error("divider started while busy");
   a_div_done_idle: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |=> !stat.div_busy) else $error("divider busy after done");
   a_issue_stalled: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> req_stall && !rsp_valid) else $error("lane sweep while idle");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;

   localparam int HIDDEN = 128;
   localparam int PAUSE  = 400;
   localparam int BATCH  = 64;

   typedef struct {
      logic [2:0]         op;
      logic [9:0]         row;
      logic [6:0]         lane;
      logic signed [15:0] weight_value;
      logic [2:0]         piece;
      logic [5:0]         square;
      logic               white_piece;
      logic               white_turn;
   } request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [2:0]              req_op = '0;
   logic [9:0]              req_row = '0;
   logic [6:0]              req_lane = '0;
   logic signed [15:0]      req_weight_value = '0;
   logic [2:0]              req_piece = '0;
   logic [5:0]              req_square = '0;
   logic                    req_white_piece = 1'b0;
   logic                    req_white_turn = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [15:0]      rsp_score;
   logic                    csr_write_enable = 1'b0;
   logic [2:0]              csr_index = '0;
   logic [15:0]             csr_write_data = '0;

   nnue_accumulator_evaluator #(.HIDDEN(HIDDEN)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_row(req_row),
      .req_lane(req_lane), .req_weight_value(req_weight_value), .req_piece(req_piece),
      .req_square(req_square), .req_white_piece(req_white_piece),
      .req_white_turn(req_white_turn),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_score(rsp_score),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // shadow copy of the evaluator state
   logic signed [15:0] feat_mem [0:nae_pkg::FEATURE_ROWS*HIDDEN-1];
   logic signed [15:0] bias_row [0:HIDDEN-1];
   logic signed [15:0] out_mem [0:2*HIDDEN-1];
   logic signed [15:0] acc_white [0:HIDDEN-1];
   logic signed [15:0] acc_black [0:HIDDEN-1];
   logic signed [15:0] cfg_bias;
   logic [14:0]        cfg_clip;
   logic [14:0]        cfg_quant;
   logic [15:0]        cfg_scale;
   logic [14:0]        cfg_limit;

   request_type        pending_requests[$];
   logic signed [15:0] expected_scores[$];
   int                 error_count = 0;
   int                 scores_seen = 0;
   int                 burst_left = 0;
   int                 gap_left = 0;
   int                 hold_left = 0;
   bit                 hold_done = 0;
   int                 stall_mode = 0;
   int                 mode_left = 0;

   // piece/square pairs whose feature rows are fully written
   int                 ready_piece [0:2] = '{0, 5, 3};
   int                 ready_square [0:2] = '{0, 63, 21};

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 6_000_000);
      $display("testbench failed");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic void apply_feature(ref logic signed [15:0] acc [0:HIDDEN-1],
                                         input int row, input bit subtract);
      for (int i = 0; i < HIDDEN; i++)
         acc[i] = subtract ? acc[i] - feat_mem[row*HIDDEN+i] : acc[i] + feat_mem[row*HIDDEN+i];
   endfunction

   function automatic logic signed [15:0] predict_score(input bit wtm);
      int                 qa;
      longint             qb;
      int                 c;
      int                 sum;
      logic signed [31:0] prod;
      logic signed [15:0] prod16;
      logic signed [15:0] lane_val;
      longint             s;
      qa = (cfg_clip == 0) ? 1 : int'(cfg_clip);
      qb = (cfg_quant == 0) ? 64'sd1 : longint'(cfg_quant);
      sum = 0;
      for (int side = 0; side < 2; side++) begin
         for (int i = 0; i < HIDDEN; i++) begin
            lane_val = ((wtm != 0) == (side == 0)) ? acc_white[i] : acc_black[i];
            c = int'(lane_val);
            if (c < 0) c = 0;
            if (c > qa) c = qa;
            prod = c * int'(out_mem[side*HIDDEN+i]);
            prod16 = prod[15:0];
            sum = sum + c * int'(prod16);
         end
      end
      s = longint'(sum) / longint'(qa);
      s = s + longint'(cfg_bias);
      s = s * longint'(cfg_scale);
      s = s / (longint'(qa) * qb);
      if (s > longint'(cfg_limit)) s = longint'(cfg_limit);
      if (s < -longint'(cfg_limit)) s = -longint'(cfg_limit);
      return s[15:0];
   endfunction

   function automatic void step_model(input request_type r);
      int  sq;
      bit  sub;
      sq = int'(r.square);
      sub = (r.op == nae_pkg::OP_REM_PIECE);
      case (r.op)
         nae_pkg::OP_WR_FEATURE:
            if (r.row < nae_pkg::FEATURE_ROWS) feat_mem[r.row*HIDDEN+r.lane] = r.weight_value;
         nae_pkg::OP_WR_BIAS:    bias_row[r.lane] = r.weight_value;
         nae_pkg::OP_WR_OUTPUT:  if (r.row <= 1) out_mem[r.row*HIDDEN+r.lane] = r.weight_value;
         nae_pkg::OP_RESET_ACC: begin
            acc_white = bias_row;
            acc_black = bias_row;
         end
         nae_pkg::OP_ADD_PIECE, nae_pkg::OP_REM_PIECE: begin
            if (r.piece < nae_pkg::PIECE_KINDS) begin
               if (r.white_piece) begin
                  apply_feature(acc_white, 64*r.piece + sq, sub);
                  apply_feature(acc_black, 64*(6+r.piece) + (sq ^ 56), sub);
               end else begin
                  apply_feature(acc_black, 64*r.piece + (sq ^ 56), sub);
                  apply_feature(acc_white, 64*(6+r.piece) + sq, sub);
               end
            end
         end
         nae_pkg::OP_EVALUATE: expected_scores.push_back(predict_score(r.white_turn));
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_model(pending_requests.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_valid <= 1'b1;
               req_op <= pending_requests[0].op;
               req_row <= pending_requests[0].row;
               req_lane <= pending_requests[0].lane;
               req_weight_value <= pending_requests[0].weight_value;
               req_piece <= pending_requests[0].piece;
               req_square <= pending_requests[0].square;
               req_white_piece <= pending_requests[0].white_piece;
               req_white_turn <= pending_requests[0].white_turn;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 60);
                  gap_left <= ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && scores_seen >= 40) begin
         rsp_stall <= 1'b1;
         hold_left <= 3000;
         hold_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom % 3;
            mode_left <= $urandom_range(16, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            1: rsp_stall <= 1'($urandom % 2);
            2: rsp_stall <= ($urandom % 5 != 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // score monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scores_seen <= scores_seen + 1;
         if (expected_scores.size() == 0) begin
            report($sformatf("unexpected score %0d", rsp_score));
         end else if (rsp_score !== expected_scores[0]) begin
            report($sformatf("score %0d, expected %0d", rsp_score, expected_scores[0]));
            void'(expected_scores.pop_front());
         end else begin
            void'(expected_scores.pop_front());
         end
      end
   end

   function automatic request_type random_request(input logic [2:0] op);
      request_type r;
      r.op = op;
      r.row = 10'($urandom);
      r.lane = 7'($urandom);
      r.weight_value = 16'($urandom);
      r.piece = 3'($urandom);
      r.square = 6'($urandom);
      r.white_piece = 1'($urandom);
      r.white_turn = 1'($urandom);
      return r;
   endfunction

   function automatic logic signed [15:0] random_weight();
      case ($urandom % 4)
         0: return 16'($urandom);
         1: return ($urandom % 2) ? 16'sh7fff : 16'sh8000;
         default: return 16'($signed($urandom_range(0, 160)) - 80);
      endcase
   endfunction

   task automatic send(input request_type r);
      pending_requests.push_back(r);
   endtask

   task automatic send_write(input logic [2:0] op, input int row, input int lane,
                             input logic signed [15:0] value);
      request_type r;
      r = random_request(op);
      if (op != nae_pkg::OP_WR_BIAS) r.row = 10'(row);
      r.lane = 7'(lane);
      r.weight_value = value;
      send(r);
   endtask

   task automatic send_piece(input logic [2:0] op, input int k, input bit white);
      request_type r;
      r = random_request(op);
      r.piece = 3'(ready_piece[k]);
      r.square = 6'(white ? ready_square[k] : (ready_square[k] ^ 56));
      r.white_piece = white;
      send(r);
   endtask

   task automatic send_evaluate(input bit wtm);
      request_type r;
      r = random_request(nae_pkg::OP_EVALUATE);
      r.white_turn = wtm;
      send(r);
   endtask

   task automatic send_random();
      request_type r;
      int          pick;
      int          k;
      pick = int'($urandom % 100);
      k = int'($urandom % 3);
      if (pick < 30) send_piece(nae_pkg::OP_ADD_PIECE, k, 1'($urandom % 2));
      else if (pick < 42) send_piece(nae_pkg::OP_REM_PIECE, k, 1'($urandom % 2));
      else if (pick < 65) send_evaluate(1'($urandom % 2));
      else if (pick < 69) send(random_request(nae_pkg::OP_RESET_ACC));
      else if (pick < 75) send_write(nae_pkg::OP_WR_FEATURE,
                                     $urandom_range(0, nae_pkg::FEATURE_ROWS-1),
                                     int'($urandom % HIDDEN), random_weight());
      else if (pick < 79) send_write(nae_pkg::OP_WR_BIAS, 0, int'($urandom % HIDDEN),
                                     random_weight());
      else if (pick < 84) send_write(nae_pkg::OP_WR_OUTPUT, int'($urandom % 2),
                                     int'($urandom % HIDDEN), random_weight());
      else if (pick < 88) send_write(nae_pkg::OP_WR_FEATURE,
                                     ($urandom % 2) ? 64*ready_piece[k] + ready_square[k]
                                        : 64*(6+ready_piece[k]) + (ready_square[k] ^ 56),
                                     int'($urandom % HIDDEN), random_weight());
      else begin
         case ($urandom % 4)
            0: send(random_request(nae_pkg::OP_UNUSED));
            1: begin
               r = random_request(($urandom % 2) ? nae_pkg::OP_ADD_PIECE
                                                 : nae_pkg::OP_REM_PIECE);
               r.piece = 3'($urandom_range(6, 7));
               send(r);
            end
            2: send_write(nae_pkg::OP_WR_FEATURE, $urandom_range(nae_pkg::FEATURE_ROWS, 1023),
                          int'($urandom % HIDDEN), random_weight());
            default: send_write(nae_pkg::OP_WR_OUTPUT, $urandom_range(2, 1023),
                                int'($urandom % HIDDEN), random_weight());
         endcase
      end
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_scores.size() != 0)
         @(posedge clock);
      repeat (PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         nae_pkg::CSR_OUTPUT_BIAS:  cfg_bias = data;
         nae_pkg::CSR_CLIP_CEILING: cfg_clip = data[14:0];
         nae_pkg::CSR_OUTPUT_QUANT: cfg_quant = data[14:0];
         nae_pkg::CSR_EVAL_SCALE:   cfg_scale = data;
         default:                   cfg_limit = data[14:0];
      endcase
   endtask

   task automatic configure(input int bias, input int clip, input int quant,
                            input int scale, input int limit);
      write_csr(nae_pkg::CSR_OUTPUT_BIAS, 16'(bias));
      write_csr(nae_pkg::CSR_CLIP_CEILING, 16'(clip));
      write_csr(nae_pkg::CSR_OUTPUT_QUANT, 16'(quant));
      write_csr(nae_pkg::CSR_EVAL_SCALE, 16'(scale));
      write_csr(nae_pkg::CSR_EVAL_LIMIT, 16'(limit));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      request_type r;
      cfg_bias = nae_pkg::RST_OUTPUT_BIAS;
      cfg_clip = nae_pkg::RST_CLIP_CEILING;
      cfg_quant = nae_pkg::RST_OUTPUT_QUANT;
      cfg_scale = nae_pkg::RST_EVAL_SCALE;
      cfg_limit = nae_pkg::RST_EVAL_LIMIT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // load every weight that a later request reads
      for (int i = 0; i < HIDDEN; i++)
         send_write(nae_pkg::OP_WR_BIAS, 0, i,
                    i == 0 ? 16'sh7fff : i == 1 ? 16'sh8000 : random_weight());
      for (int i = 0; i < 2*HIDDEN; i++)
         send_write(nae_pkg::OP_WR_OUTPUT, i / HIDDEN, i % HIDDEN,
                    i == 0 ? 16'sh8000 : i == 1 ? 16'sh7fff : random_weight());
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < HIDDEN; i++) begin
            send_write(nae_pkg::OP_WR_FEATURE, 64*ready_piece[k] + ready_square[k], i,
                       random_weight());
            send_write(nae_pkg::OP_WR_FEATURE, 64*(6+ready_piece[k]) + (ready_square[k] ^ 56),
                       i, random_weight());
         end
      end

      // directed requests
      send(random_request(nae_pkg::OP_RESET_ACC));
      send_evaluate(1'b0);
      send_evaluate(1'b1);
      for (int k = 0; k < 3; k++) begin
         send_piece(nae_pkg::OP_ADD_PIECE, k, 1'b1);
         send_piece(nae_pkg::OP_ADD_PIECE, k, 1'b0);
      end
      send_evaluate(1'b1);
      send_piece(nae_pkg::OP_REM_PIECE, 1, 1'b1);
      send_evaluate(1'b0);
      send(random_request(nae_pkg::OP_UNUSED));
      r = random_request(nae_pkg::OP_ADD_PIECE);
      r.piece = nae_pkg::PIECE_KINDS;
      send(r);
      r = random_request(nae_pkg::OP_REM_PIECE);
      r.piece = 3'd7;
      send(r);
      send_write(nae_pkg::OP_WR_FEATURE, 1023, 127, 16'sh7fff);
      send_write(nae_pkg::OP_WR_OUTPUT, 3, 5, 16'sh8000);
      send_evaluate(1'b1);
      for (int n = 0; n < BATCH; n++) send_random();
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure(32767, 1, 1, 65535, 32767);
            1: configure(-32768, 32767, 32767, 1, 0);
            2: configure(-5, 30, 1, 65535, 32767);
            3: configure(100, 255, 64, 400, 9999);
            default: configure(int'($urandom), $urandom_range(1, 2000), $urandom_range(1, 200),
                               $urandom_range(1, 65535), $urandom_range(0, 32767));
         endcase
         for (int n = 0; n < BATCH; n++) send_random();
         drain();
      end

      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
